// ===== sv/sobel_pkg.sv =====
// ============================================================================
// sobel_pkg: shared types and constants of the Sobel edge magnitude block
// Register indexes, field widths, reset values and arithmetic constants.
// ============================================================================
package sobel_pkg;

    // Widths of the fixed fields.
    localparam int PIX_W = 8;   // one color channel or one gray value
    localparam int CFG_W = 12;  // configuration data
    localparam int POS_W = 11;  // column and row of a result

    // Configuration register indexes.
    typedef enum logic [0:0] {
        CFG_FRAME_WIDTH  = 1'b0,
        CFG_FRAME_HEIGHT = 1'b1
    } t_cfg_index;

    localparam logic [CFG_W-1:0] FRAME_WIDTH_RESET  = 12'd640;
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RESET = 12'd480;
    localparam int               MIN_DIM            = 3;

    // Gray conversion: floor(sum/3) = (sum * 683) >> 11 for any sum up to 765.
    localparam int SUM_W      = 10;
    localparam int DIV3_MUL   = 683;
    localparam int DIV3_SHIFT = 11;
    localparam int PROD_W     = 20;

    // Gradient arithmetic.
    localparam int GRAD_W = 12;  // signed gradient, magnitude up to 1020
    localparam int SQ_W   = 20;  // one squared gradient
    localparam int EN_W   = 21;  // sum of both squares
    localparam int ROOT_W = 16;  // root operand once saturation is split off

    localparam logic [PIX_W-1:0] MAG_MAX = 8'd255;

endpackage

// ===== sv/sobel_ram.sv =====
// ============================================================================
// sobel_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; read data appears in the cycle
// after the read enable.
// ============================================================================
module sobel_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/sobel_edge_magnitude_3x3.sv =====
// ============================================================================
// sobel_edge_magnitude_3x3: streaming 3x3 Sobel edge magnitude
// RGB pixels in raster order in, one magnitude word per interior center out.
// ============================================================================
// Pixels arrive in raster order and are converted to gray as floor((r+g+b)/3).
// Two line-store RAMs hold the gray values of the two previous rows and six
// taps hold the two previous columns; each interior center produces one word
// carrying its column, row and floor(sqrt(gx^2+gy^2)) saturated at 255, issued
// when the pixel one row below and one column right arrives. Border pixels
// produce nothing. frame_start forces the pixel to column 0, row 0, and the
// position also wraps by itself after the last pixel of a frame. A pixel that
// produces no word has both line stores read at its column and then written
// back. A pixel that produces a word goes on from the write-back through a
// squaring stage, a summing stage, 8 steps of the iterative square root and a
// hand-off to the output register. The output register lets the next pixel
// enter while a finished word waits. Frame width and height are taken from the
// configuration port, clamped to 3..MAX_WIDTH and 3..MAX_HEIGHT.
module sobel_edge_magnitude_3x3 #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // configuration
    input  logic                         i_cfg_we,
    input  sobel_pkg::t_cfg_index        i_cfg_index,
    input  logic [sobel_pkg::CFG_W-1:0]  i_cfg_data,
    // pixel input
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [sobel_pkg::PIX_W-1:0]  i_red,
    input  logic [sobel_pkg::PIX_W-1:0]  i_green,
    input  logic [sobel_pkg::PIX_W-1:0]  i_blue,
    input  logic                         i_frame_start,
    // magnitude output
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [sobel_pkg::POS_W-1:0]  o_column,
    output logic [sobel_pkg::POS_W-1:0]  o_row,
    output logic [sobel_pkg::PIX_W-1:0]  o_magnitude,
    output logic                         o_end_of_frame
);

    localparam int CW  = $clog2(MAX_WIDTH);       // column counter / RAM address
    localparam int RW  = $clog2(MAX_HEIGHT);      // row counter
    localparam int WW  = $clog2(MAX_WIDTH + 1);   // effective width
    localparam int HW  = $clog2(MAX_HEIGHT + 1);  // effective height

    localparam int PW = sobel_pkg::PIX_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CALC,
        S_SQUARE,
        S_SUM,
        S_ROOT,
        S_DONE
    } t_state;

    t_state r_state;

    logic [sobel_pkg::CFG_W-1:0] r_cfg_width;
    logic [sobel_pkg::CFG_W-1:0] r_cfg_height;

    logic [CW-1:0] r_col_cnt;
    logic [RW-1:0] r_row_cnt;
    logic [CW-1:0] r_col;       // position of the pixel at work
    logic [RW-1:0] r_row;
    logic [PW-1:0] r_gray;
    logic [PW-1:0] r_taps [6];

    logic signed [sobel_pkg::GRAD_W-1:0] r_gx;
    logic signed [sobel_pkg::GRAD_W-1:0] r_gy;
    logic [sobel_pkg::SQ_W-1:0]          r_sq_x;
    logic [sobel_pkg::SQ_W-1:0]          r_sq_y;
    logic                                r_sat;
    logic [sobel_pkg::ROOT_W-1:0]        r_rem;
    logic [sobel_pkg::ROOT_W-1:0]        r_res;
    logic [sobel_pkg::ROOT_W-1:0]        r_bit;
    logic                                r_eof;

    logic                        r_out_valid;
    logic [sobel_pkg::POS_W-1:0] r_out_column;
    logic [sobel_pkg::POS_W-1:0] r_out_row;
    logic [PW-1:0]               r_out_mag;
    logic                        r_out_eof;

    logic [WW-1:0] w_eff;
    logic [HW-1:0] h_eff;
    logic          in_accept;
    logic          out_take;

    logic [CW-1:0] n_col;
    logic [RW-1:0] n_row;
    logic [HW-1:0] row_inc;
    logic [CW-1:0] n_col_cnt;
    logic [RW-1:0] n_row_cnt;

    logic [sobel_pkg::SUM_W-1:0]  rgb_sum;
    logic [sobel_pkg::PROD_W-1:0] div3_prod;
    logic [PW-1:0]                gray;

    logic [PW-1:0]                 top_rd;
    logic [PW-1:0]                 mid_rd;
    logic [sobel_pkg::GRAD_W-1:0]  sum_right, sum_left, sum_bottom, sum_top;
    logic [sobel_pkg::EN_W-1:0]    energy;
    logic [sobel_pkg::ROOT_W:0]    trial;
    logic                          emit;
    logic                          at_last;

    // ---------------------------------------------------------------- config
    always_comb begin
        if (r_cfg_width < sobel_pkg::CFG_W'(sobel_pkg::MIN_DIM)) begin
            w_eff = WW'(sobel_pkg::MIN_DIM);
        end else if (32'(r_cfg_width) > MAX_WIDTH) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(r_cfg_width);
        end
        if (r_cfg_height < sobel_pkg::CFG_W'(sobel_pkg::MIN_DIM)) begin
            h_eff = HW'(sobel_pkg::MIN_DIM);
        end else if (32'(r_cfg_height) > MAX_HEIGHT) begin
            h_eff = HW'(MAX_HEIGHT);
        end else begin
            h_eff = HW'(r_cfg_height);
        end
    end

    assign in_accept = i_valid && !o_stall;
    assign out_take  = r_out_valid && !i_stall;
    assign o_stall   = (r_state != S_IDLE);

    // Position of the arriving pixel, after frame_start and any wrap caused
    // by a size that shrank since the counters were last updated.
    always_comb begin
        logic [CW-1:0] fc;
        logic [HW-1:0] fr;
        fc = i_frame_start ? '0 : r_col_cnt;
        fr = i_frame_start ? '0 : HW'(r_row_cnt);
        if (WW'(fc) >= w_eff) begin
            fc = '0;
            fr = fr + HW'(1);
        end
        if (fr >= h_eff) begin
            fr = '0;
        end
        n_col = fc;
        n_row = RW'(fr);
    end

    // Gray value by multiplying with the reciprocal of three.
    assign rgb_sum   = sobel_pkg::SUM_W'(i_red) + sobel_pkg::SUM_W'(i_green)
                     + sobel_pkg::SUM_W'(i_blue);
    assign div3_prod = sobel_pkg::PROD_W'(rgb_sum) * sobel_pkg::PROD_W'(sobel_pkg::DIV3_MUL);
    assign gray      = div3_prod[sobel_pkg::DIV3_SHIFT +: PW];

    // ----------------------------------------------------------- line stores
    sobel_ram #(
        .WIDTH (PW),
        .DEPTH (MAX_WIDTH)
    ) u_upper_line (
        .i_clk   (i_clk),
        .i_we    (r_state == S_CALC),
        .i_waddr (r_col),
        .i_wdata (mid_rd),
        .i_re    (in_accept),
        .i_raddr (n_col),
        .o_rdata (top_rd)
    );

    sobel_ram #(
        .WIDTH (PW),
        .DEPTH (MAX_WIDTH)
    ) u_middle_line (
        .i_clk   (i_clk),
        .i_we    (r_state == S_CALC),
        .i_waddr (r_col),
        .i_wdata (r_gray),
        .i_re    (in_accept),
        .i_raddr (n_col),
        .o_rdata (mid_rd)
    );

    // ---------------------------------------------------------------- window
    // Taps: 0/1/2 = top/mid/bottom two columns back, 3/4/5 = one column back.
    assign sum_right  = sobel_pkg::GRAD_W'(top_rd)
                        + {(sobel_pkg::GRAD_W - 1)'(mid_rd), 1'b0}
                        + sobel_pkg::GRAD_W'(r_gray);
    assign sum_left   = sobel_pkg::GRAD_W'(r_taps[0])
                        + {(sobel_pkg::GRAD_W - 1)'(r_taps[1]), 1'b0}
                        + sobel_pkg::GRAD_W'(r_taps[2]);
    assign sum_bottom = sobel_pkg::GRAD_W'(r_taps[2])
                        + {(sobel_pkg::GRAD_W - 1)'(r_taps[5]), 1'b0}
                        + sobel_pkg::GRAD_W'(r_gray);
    assign sum_top    = sobel_pkg::GRAD_W'(r_taps[0])
                        + {(sobel_pkg::GRAD_W - 1)'(r_taps[3]), 1'b0}
                        + sobel_pkg::GRAD_W'(top_rd);

    assign emit    = (r_col >= CW'(2)) && (r_row >= RW'(2));
    assign at_last = (WW'(r_col) == w_eff - WW'(1)) && (HW'(r_row) == h_eff - HW'(1));

    // Position counters after the pixel at work.
    always_comb begin
        logic [WW-1:0] cn;
        cn      = WW'(r_col) + WW'(1);
        row_inc = HW'(r_row) + HW'(1);
        if (cn >= w_eff) begin
            n_col_cnt = '0;
            n_row_cnt = (row_inc >= h_eff) ? '0 : RW'(row_inc);
        end else begin
            n_col_cnt = CW'(cn);
            n_row_cnt = r_row;
        end
    end

    assign energy = sobel_pkg::EN_W'(r_sq_x) + sobel_pkg::EN_W'(r_sq_y);
    assign trial  = (sobel_pkg::ROOT_W + 1)'(r_res) + (sobel_pkg::ROOT_W + 1)'(r_bit);

    // ------------------------------------------------------------- sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_cfg_width  <= sobel_pkg::FRAME_WIDTH_RESET;
            r_cfg_height <= sobel_pkg::FRAME_HEIGHT_RESET;
            r_col_cnt    <= '0;
            r_row_cnt    <= '0;
            r_out_valid  <= 1'b0;
            for (int i = 0; i < 6; i++) begin
                r_taps[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    sobel_pkg::CFG_FRAME_WIDTH:  r_cfg_width  <= i_cfg_data;
                    sobel_pkg::CFG_FRAME_HEIGHT: r_cfg_height <= i_cfg_data;
                    default: ;
                endcase
            end

            // In S_DONE a taken word is replaced by the finished one below.
            if (out_take && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        r_col   <= n_col;
                        r_row   <= n_row;
                        r_gray  <= gray;
                        r_state <= S_CALC;
                    end
                end
                S_CALC: begin
                    r_gx      <= $signed(sum_right) - $signed(sum_left);
                    r_gy      <= $signed(sum_bottom) - $signed(sum_top);
                    r_eof     <= at_last;
                    r_taps[0] <= r_taps[3];
                    r_taps[1] <= r_taps[4];
                    r_taps[2] <= r_taps[5];
                    r_taps[3] <= top_rd;
                    r_taps[4] <= mid_rd;
                    r_taps[5] <= r_gray;
                    r_col_cnt <= n_col_cnt;
                    r_row_cnt <= n_row_cnt;
                    r_state   <= emit ? S_SQUARE : S_IDLE;
                end
                S_SQUARE: begin
                    r_sq_x  <= sobel_pkg::SQ_W'(r_gx * r_gx);
                    r_sq_y  <= sobel_pkg::SQ_W'(r_gy * r_gy);
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    // Any energy of 2^16 or more has a root above 255.
                    r_sat   <= |energy[sobel_pkg::EN_W-1:sobel_pkg::ROOT_W];
                    r_rem   <= energy[sobel_pkg::ROOT_W-1:0];
                    r_res   <= '0;
                    r_bit   <= sobel_pkg::ROOT_W'(1) << (sobel_pkg::ROOT_W - 2);
                    r_state <= S_ROOT;
                end
                S_ROOT: begin
                    if ((sobel_pkg::ROOT_W + 1)'(r_rem) >= trial) begin
                        r_rem <= r_rem - sobel_pkg::ROOT_W'(trial);
                        r_res <= (r_res >> 1) + r_bit;
                    end else begin
                        r_res <= r_res >> 1;
                    end
                    r_bit <= r_bit >> 2;
                    if (r_bit[0]) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || !i_stall) begin
                        r_out_valid  <= 1'b1;
                        r_out_column <= sobel_pkg::POS_W'(r_col - CW'(1));
                        r_out_row    <= sobel_pkg::POS_W'(r_row - RW'(1));
                        r_out_mag    <= r_sat ? sobel_pkg::MAG_MAX : r_res[PW-1:0];
                        r_out_eof    <= r_eof;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid        = r_out_valid;
    assign o_column       = r_out_column;
    assign o_row          = r_out_row;
    assign o_magnitude    = r_out_mag;
    assign o_end_of_frame = r_out_eof;

`ifndef SYNTH
    // An accepted pixel always goes on to its line-store write-back.
    a_accept_to_calc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> r_state == S_CALC)
        else $error("accepted pixel did not reach the write-back cycle");

    // The root bit walks down as a single set bit.
    a_root_bit_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_ROOT |-> $onehot(r_bit))
        else $error("square root step bit is not one-hot");

    // A finished word with a free output register is delivered at once.
    a_done_handoff: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && !r_out_valid) |=> (r_out_valid && r_state == S_IDLE))
        else $error("finished word was not handed to the output register");

    // Only pixels at column 2 or beyond and row 2 or beyond reach the root.
    a_root_interior: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SQUARE |-> (r_col >= CW'(2) && r_row >= RW'(2)))
        else $error("border pixel entered the magnitude path");
`endif

endmodule

// ===== tb/tb_sobel_edge_magnitude_3x3.sv =====
// ============================================================================
// tb_sobel_edge_magnitude_3x3: self-checking bench for the Sobel edge block
// Streams RGB pixels through the block while both sides idle at random, keeps
// its own line stores and 3x3 window to predict every magnitude word, and
// compares each word that leaves the block with the oldest prediction.
// ============================================================================
module tb_sobel_edge_magnitude_3x3;
    timeunit 1ns;
    timeprecision 1ps;

    import sobel_pkg::*;

    localparam int MAX_DIM         = 2048;
    localparam int SETTLE_CYCLES   = 24;
    localparam int RESET_PIXELS    = 40;
    localparam int CLAMP_PIXELS    = 48;
    localparam int RANDOM_PIXELS   = 720;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int REPORT_LIMIT    = 10;

    typedef struct packed {
        logic [POS_W-1:0] column;
        logic [POS_W-1:0] row;
        logic [PIX_W-1:0] magnitude;
        logic             end_of_frame;
    } t_edge_word;

    typedef enum int {PAT_NOISE, PAT_FLAT_GRAY, PAT_BINARY, PAT_SMOOTH} t_pattern;

    // Three 3x3 frames: mixed channel extremes, a vertical edge, a horizontal
    // edge. A stray pixel sits between the first two to test a restart.
    localparam logic [23:0] DIRECTED_PIXELS [28] = '{
        24'hFF0000, 24'h00FF00, 24'h0000FF,
        24'hFFFFFF, 24'h000000, 24'h010101,
        24'hFEFEFE, 24'h804020, 24'hFFFFFE,
        24'h070707,
        24'h000000, 24'h5A5A5A, 24'hFFFFFF,
        24'h000000, 24'h5A5A5A, 24'hFFFFFF,
        24'h000000, 24'h5A5A5A, 24'hFFFFFF,
        24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
        24'h646464, 24'h646464, 24'h646464,
        24'h000000, 24'h000000, 24'h000000
    };
    localparam int RESTART_INDEX = 10;

    logic             i_clk          = 1'b0;
    logic             i_rst_n        = 1'b0;
    logic             i_cfg_we       = 1'b0;
    t_cfg_index       i_cfg_index    = CFG_FRAME_WIDTH;
    logic [CFG_W-1:0] i_cfg_data     = '0;
    logic             i_valid        = 1'b0;
    logic             o_stall;
    logic [PIX_W-1:0] i_red          = '0;
    logic [PIX_W-1:0] i_green        = '0;
    logic [PIX_W-1:0] i_blue         = '0;
    logic             i_frame_start  = 1'b0;
    logic             o_valid;
    logic             i_stall        = 1'b0;
    logic [POS_W-1:0] o_column;
    logic [POS_W-1:0] o_row;
    logic [PIX_W-1:0] o_magnitude;
    logic             o_end_of_frame;

    sobel_edge_magnitude_3x3 dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_red          (i_red),
        .i_green        (i_green),
        .i_blue         (i_blue),
        .i_frame_start  (i_frame_start),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_column       (o_column),
        .o_row          (o_row),
        .o_magnitude    (o_magnitude),
        .o_end_of_frame (o_end_of_frame)
    );

    // Shadow of the block's state.
    logic [PIX_W-1:0] line_upper  [MAX_DIM] = '{default: '0};
    logic [PIX_W-1:0] line_middle [MAX_DIM] = '{default: '0};
    int               left_taps   [3]       = '{default: 0};
    int               centre_taps [3]       = '{default: 0};
    int               next_col              = 0;
    int               next_row              = 0;
    logic [CFG_W-1:0] width_reg             = FRAME_WIDTH_RESET;
    logic [CFG_W-1:0] height_reg            = FRAME_HEIGHT_RESET;

    // Narrowest width in force since the current frame began; a wider row
    // would read line-store columns that no row of this frame has written.
    int frame_bound     = int'(FRAME_WIDTH_RESET);
    bit restart_needed  = 1'b0;

    t_edge_word pending_edges [$];
    int         mismatch_total = 0;
    bit         no_gaps        = 1'b0;
    int         smooth_shade   = 128;
    int         hold_requests  = 0;
    int         hold_served    = 0;
    int         hold_left      = 0;

    always #5 i_clk = ~i_clk;

    function automatic int effective_dim(input logic [CFG_W-1:0] value);
        if (value < MIN_DIM) return MIN_DIM;
        if (value > MAX_DIM) return MAX_DIM;
        return int'(value);
    endfunction

    function automatic int floor_root(input int energy);
        int root;
        int trial;
        root = 0;
        for (int b = 11; b >= 0; b--) begin
            trial = root + (1 << b);
            if (trial * trial <= energy) root = trial;
        end
        return root;
    endfunction

    task automatic predict_edge_pixel(input logic [PIX_W-1:0] red, green, blue,
                                      input logic start);
        int w, h, col, row, gray, top, mid, gx, gy, mag;
        t_edge_word word;
        w = effective_dim(width_reg);
        h = effective_dim(height_reg);
        if (start) begin
            next_col = 0;
            next_row = 0;
            frame_bound = w;
        end else if (w < frame_bound) begin
            frame_bound = w;
        end
        if (next_col >= w) begin
            next_col = 0;
            next_row++;
        end
        if (next_row >= h) next_row = 0;
        col = next_col;
        row = next_row;

        gray = (int'(red) + int'(green) + int'(blue)) / 3;
        top  = int'(line_upper[col]);
        mid  = int'(line_middle[col]);

        if (col >= 2 && row >= 2) begin
            gx = (top + 2 * mid + gray) - (left_taps[0] + 2 * left_taps[1] + left_taps[2]);
            gy = (left_taps[2] + 2 * centre_taps[2] + gray)
               - (left_taps[0] + 2 * centre_taps[0] + top);
            mag = floor_root(gx * gx + gy * gy);
            word.column       = POS_W'(col - 1);
            word.row          = POS_W'(row - 1);
            word.magnitude    = (mag > int'(MAG_MAX)) ? MAG_MAX : PIX_W'(mag);
            word.end_of_frame = (col == w - 1) && (row == h - 1);
            pending_edges.push_back(word);
        end

        left_taps   = centre_taps;
        centre_taps = '{top, mid, gray};
        line_upper[col]  = PIX_W'(mid);
        line_middle[col] = PIX_W'(gray);

        next_col = col + 1;
        if (next_col >= w) begin
            next_col = 0;
            next_row = row + 1;
            if (next_row >= h) next_row = 0;
        end
    endtask

    task automatic log_failure(input string msg);
        mismatch_total++;
        if (mismatch_total <= REPORT_LIMIT) $display("MISMATCH at %0t ns: %s", $time, msg);
    endtask

    always @(posedge i_clk) begin
        t_edge_word want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_edges.size() == 0) begin
                log_failure($sformatf("unexpected word col %0d row %0d mag %0d eof %0d",
                                      o_column, o_row, o_magnitude, o_end_of_frame));
            end else begin
                want = pending_edges.pop_front();
                if (o_column !== want.column || o_row !== want.row ||
                    o_magnitude !== want.magnitude ||
                    o_end_of_frame !== want.end_of_frame) begin
                    log_failure($sformatf({"expected col %0d row %0d mag %0d eof %0d, ",
                                           "got col %0d row %0d mag %0d eof %0d"},
                                          want.column, want.row, want.magnitude,
                                          want.end_of_frame, o_column, o_row,
                                          o_magnitude, o_end_of_frame));
                end
            end
        end
    end

    // Output side: random stalls, or a long hold-off when a test asks for one.
    always @(posedge i_clk) begin
        if (hold_served != hold_requests) begin
            hold_served++;
            hold_left = HOLD_OFF_CYCLES;
        end
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= !no_gaps && ($urandom_range(99) < 7);
        end
    end

    task automatic send_pixel(input logic [23:0] rgb, input logic start);
        while (!no_gaps && $urandom_range(99) < 7) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_red         <= rgb[23:16];
        i_green       <= rgb[15:8];
        i_blue        <= rgb[7:0];
        i_frame_start <= start;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predict_edge_pixel(rgb[23:16], rgb[15:8], rgb[7:0], start);
    endtask

    // Waits on the clock before it returns when settle is positive, so valid is
    // never lowered and raised again in the same step.
    task automatic wait_for_words(input int settle);
        i_valid <= 1'b0;
        while (pending_edges.size() != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic write_register(input t_cfg_index index, input logic [CFG_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        if (index == CFG_FRAME_WIDTH) width_reg = value;
        else height_reg = value;
    endtask

    task automatic set_geometry(input logic [CFG_W-1:0] width_val, height_val);
        wait_for_words(SETTLE_CYCLES);
        write_register(CFG_FRAME_WIDTH, width_val);
        write_register(CFG_FRAME_HEIGHT, height_val);
        restart_needed = effective_dim(width_val) > frame_bound;
    endtask

    function automatic logic [23:0] pattern_pixel(input t_pattern pat);
        logic [7:0] g;
        case (pat)
            PAT_FLAT_GRAY: begin
                g = 8'($urandom_range(255));
                return {g, g, g};
            end
            PAT_BINARY: return $urandom_range(1) ? 24'hFFFFFF : 24'h000000;
            PAT_SMOOTH: begin
                smooth_shade = smooth_shade + int'($urandom_range(16)) - 8;
                if (smooth_shade < 0) smooth_shade = 0;
                if (smooth_shade > 255) smooth_shade = 255;
                g = 8'(smooth_shade);
                return {g, g, g};
            end
            default: return 24'($urandom);
        endcase
    endfunction

    // Reset geometry: the first pixels after reset fill row 0 of a 640-pixel
    // frame from column 0 and give no word.
    task automatic test_reset_geometry();
        for (int i = 0; i < RESET_PIXELS; i++) begin
            send_pixel(pattern_pixel(PAT_NOISE), 1'b0);
        end
    endtask

    // Low register values clamp to a 3x3 frame; covers channel extremes,
    // a restart in mid-frame, saturation on both kernels and the frame wrap.
    task automatic test_directed_corners();
        set_geometry(12'd0, 12'd2);
        for (int i = 0; i < 28; i++) begin
            send_pixel(DIRECTED_PIXELS[i], (i == 0) || (i == RESTART_INDEX));
        end
    endtask

    // High register values clamp to the widest and tallest frames, so neither
    // a row nor a frame may end early. Both sides run without gaps here.
    task automatic test_clamped_extremes();
        no_gaps = 1'b1;
        set_geometry(12'hFFF, 12'd3);
        for (int i = 0; i < CLAMP_PIXELS; i++) begin
            send_pixel(pattern_pixel(PAT_NOISE), i == 0);
        end
        set_geometry(12'd3, 12'hFFF);
        for (int i = 0; i < CLAMP_PIXELS; i++) begin
            send_pixel(pattern_pixel(PAT_NOISE), i == 0);
        end
        wait_for_words(SETTLE_CYCLES);
        no_gaps = 1'b0;
    endtask

    // The receiver holds off long enough for the block to fill and stall its
    // input; then the sender pauses until every word is out.
    task automatic test_backpressure();
        set_geometry(12'd4, 12'd40);
        hold_requests++;
        for (int i = 0; i < 80; i++) send_pixel(pattern_pixel(PAT_NOISE), i == 0);
        wait_for_words(1);
        for (int i = 0; i < 40; i++) send_pixel(pattern_pixel(PAT_BINARY), 1'b0);
    endtask

    task automatic test_random_frames();
        int sent;
        int phase_len;
        int pick;
        t_pattern pat;
        logic [CFG_W-1:0] width_val, height_val;
        logic start;
        sent = 0;
        while (sent < RANDOM_PIXELS) begin
            pick = $urandom_range(99);
            if (pick < 10)      width_val = CFG_W'($urandom_range(2));
            else if (pick < 14) width_val = CFG_W'($urandom_range(4095, 2049));
            else if (pick < 85) width_val = CFG_W'($urandom_range(12, 3));
            else                width_val = CFG_W'($urandom_range(40, 13));
            pick = $urandom_range(99);
            if (pick < 10)      height_val = CFG_W'($urandom_range(2));
            else if (pick < 15) height_val = CFG_W'($urandom_range(4095, 2049));
            else                height_val = CFG_W'($urandom_range(10, 3));
            set_geometry(width_val, height_val);

            pat = t_pattern'($urandom_range(3));
            phase_len = $urandom_range(120, 20);
            for (int i = 0; i < phase_len; i++) begin
                // A rare stray frame start breaks up otherwise clean frames.
                if (i == 0) start = restart_needed || $urandom_range(1);
                else start = ($urandom_range(99) < 2);
                send_pixel(pattern_pixel(pat), start);
            end
            sent += phase_len;
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_geometry();
        test_directed_corners();
        test_clamped_extremes();
        test_backpressure();
        test_random_frames();
        wait_for_words(SETTLE_CYCLES);
        if (mismatch_total == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #8ms;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== sobel_edge_magnitude_3x3.f =====
sv/sobel_pkg.sv
sv/sobel_ram.sv
sv/sobel_edge_magnitude_3x3.sv
tb/tb_sobel_edge_magnitude_3x3.sv
